// File: hdl/lfr_pkg.sv
// shared types, action codes and defaults for the led level fade ramp
`default_nettype none

package lfr_pkg;

    localparam int TIME_BITS_DEF = 32;

    localparam logic [2:0] ACT_TICK   = 3'd0;
    localparam logic [2:0] ACT_FADE   = 3'd1;
    localparam logic [2:0] ACT_LEVEL  = 3'd2;
    localparam logic [2:0] ACT_SWITCH = 3'd3;
    localparam logic [2:0] ACT_TOGGLE = 3'd4;

    localparam logic [7:0] LEVEL_MAX = 8'hFF;

    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] now_ms;
        logic [7:0]  level_a;
        logic [7:0]  level_b;
        logic [31:0] span_ms;
        logic        switch_on;
    } in_word_t;

    typedef struct packed {
        logic [7:0] drive_level;
        logic       is_on;
        logic       in_fade;
    } out_word_t;

    typedef enum logic {
        CS_IDLE,
        CS_DIVIDE
    } ctrl_state_t;

    typedef struct packed {
        logic apply;
        logic div_start;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_fade;
        logic div_done;
    } dp_status_t;

endpackage

`default_nettype wire

// File: hdl/lfr_divider.sv
// restoring divider, one quotient bit per cycle, with round-half-up flag
`default_nettype none

module lfr_divider #(
    parameter int TIME_BITS = lfr_pkg::TIME_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [TIME_BITS-1:0] dividend,
    input  wire logic [7:0]           divisor,
    output logic                      done,
    output logic [TIME_BITS-1:0]      quotient,
    output logic                      round_up
);
    import lfr_pkg::*;

    localparam int CW = $clog2(TIME_BITS + 1);

    logic [TIME_BITS-1:0] quo_reg, quo_next;
    logic [7:0]           rem_reg, rem_next;
    logic [7:0]           div_reg, div_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 done_reg, done_next;
    logic [8:0]           rem_sh;

    always_comb begin
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        count_next = count_reg;
        done_next  = 1'b0;
        rem_sh     = {rem_reg, quo_reg[TIME_BITS-1]};
        if (start) begin
            quo_next   = dividend;
            rem_next   = 8'd0;
            div_next   = divisor;
            count_next = CW'(TIME_BITS);
        end else if (count_reg != '0) begin
            if (rem_sh >= {1'b0, div_reg}) begin
                rem_next = 8'(rem_sh - {1'b0, div_reg});
                quo_next = {quo_reg[TIME_BITS-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[7:0];
                quo_next = {quo_reg[TIME_BITS-2:0], 1'b0};
            end
            count_next = count_reg - 1'b1;
            done_next  = (count_reg == CW'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    // nearest integer, halves go up
    assign round_up = ({rem_reg, 1'b0} >= {1'b0, div_reg});

endmodule

`default_nettype wire

// File: hdl/lfr_datapath.sv
// fade state, tick stepping logic, step interval divider and result register
`default_nettype none

module lfr_datapath #(
    parameter int TIME_BITS = lfr_pkg::TIME_BITS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire lfr_pkg::in_word_t  s_data,
    input  wire lfr_pkg::ctrl_cmd_t cmd,
    output lfr_pkg::dp_status_t     status,
    output lfr_pkg::out_word_t      m_data
);
    import lfr_pkg::*;

    localparam int TB = TIME_BITS;

    logic [7:0]    level_reg, level_next;
    logic          on_reg, on_next;
    logic          active_reg, active_next;
    logic          started_reg, started_next;
    logic [7:0]    from_reg, from_next;
    logic [7:0]    to_reg, to_next;
    logic [TB-1:0] len_reg, len_next;
    logic [TB-1:0] begin_reg, begin_next;
    logic [TB-1:0] last_reg, last_next;
    logic [TB-1:0] interval_reg;
    out_word_t     out_reg;

    logic [TB+31:0] now_ext, span_ext;
    logic [TB-1:0]  now_t, span_t;
    logic [TB-1:0]  begin_eff, elapsed, since_step;
    logic [7:0]     base_level, lvl;
    logic           up;
    logic [7:0]     fade_dist;

    logic          div_done;
    logic [TB-1:0] div_quo;
    logic          div_round;

    // time fields taken modulo 2^TB
    assign now_ext  = {{TB{1'b0}}, s_data.now_ms};
    assign span_ext = {{TB{1'b0}}, s_data.span_ms};
    assign now_t    = now_ext[TB-1:0];
    assign span_t   = span_ext[TB-1:0];

    assign fade_dist = (s_data.level_b > s_data.level_a) ?
                       (s_data.level_b - s_data.level_a) :
                       (s_data.level_a - s_data.level_b);

    lfr_divider #(
        .TIME_BITS(TB)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (span_t),
        .divisor  (fade_dist),
        .done     (div_done),
        .quotient (div_quo),
        .round_up (div_round)
    );

    assign status.is_fade  = (s_data.action == ACT_FADE);
    assign status.div_done = div_done;

    // tick terms
    assign base_level = started_reg ? level_reg : from_reg;
    assign begin_eff  = started_reg ? begin_reg : now_t;
    assign elapsed    = now_t - begin_eff;
    assign since_step = now_t - last_reg;
    assign up         = (to_reg > from_reg);

    always_comb begin
        level_next   = level_reg;
        on_next      = on_reg;
        active_next  = active_reg;
        started_next = started_reg;
        from_next    = from_reg;
        to_next      = to_reg;
        len_next     = len_reg;
        begin_next   = begin_reg;
        last_next    = last_reg;
        lvl          = level_reg;
        if (cmd.apply) begin
            case (s_data.action)
                ACT_TICK: begin
                    if (active_reg) begin
                        lvl          = base_level;
                        begin_next   = begin_eff;
                        started_next = 1'b1;
                        if (elapsed < len_reg) begin
                            if (to_reg != from_reg && since_step >= interval_reg) begin
                                if (up) begin
                                    if (lvl != LEVEL_MAX) lvl = lvl + 8'd1;
                                end else begin
                                    if (lvl != 8'd0) lvl = lvl - 8'd1;
                                end
                                last_next = now_t;
                            end
                        end else begin
                            lvl          = to_reg;
                            started_next = 1'b0;
                            active_next  = 1'b0;
                        end
                    end
                    level_next = lvl;
                    on_next    = (lvl != 8'd0);
                end
                ACT_FADE: begin
                    from_next    = s_data.level_a;
                    to_next      = s_data.level_b;
                    len_next     = span_t;
                    started_next = 1'b0;
                    active_next  = 1'b1;
                end
                ACT_LEVEL: begin
                    level_next = s_data.level_a;
                    on_next    = (s_data.level_a != 8'd0);
                end
                ACT_SWITCH: begin
                    on_next    = s_data.switch_on;
                    level_next = s_data.switch_on ? LEVEL_MAX : 8'd0;
                end
                ACT_TOGGLE: begin
                    on_next    = !on_reg;
                    level_next = on_reg ? 8'd0 : LEVEL_MAX;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg   <= 8'd0;
            on_reg      <= 1'b0;
            active_reg  <= 1'b0;
            started_reg <= 1'b0;
            from_reg    <= 8'd0;
            to_reg      <= 8'd0;
            len_reg     <= '0;
            begin_reg   <= '0;
            last_reg    <= '0;
        end else begin
            level_reg   <= level_next;
            on_reg      <= on_next;
            active_reg  <= active_next;
            started_reg <= started_next;
            from_reg    <= from_next;
            to_reg      <= to_next;
            len_reg     <= len_next;
            begin_reg   <= begin_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_done) begin
            interval_reg <= div_quo + TB'(div_round);
        end
        if (cmd.apply) begin
            out_reg.drive_level <= level_next;
            out_reg.is_on       <= on_next;
            out_reg.in_fade     <= active_next;
        end
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire

// File: hdl/lfr_ctrl.sv
// controller: input and result handshakes, waits out the interval divide
`default_nettype none

module lfr_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire lfr_pkg::dp_status_t status,
    output lfr_pkg::ctrl_cmd_t       cmd
);
    import lfr_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= CS_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        accept        = 1'b0;
        cmd.apply     = 1'b0;
        cmd.div_start = 1'b0;
        case (state_reg)
            CS_IDLE: begin
                // result register must be free or emptying this cycle
                s_ready = !m_valid_reg || m_ready;
                accept  = s_valid && s_ready;
                cmd.apply     = accept;
                cmd.div_start = accept && status.is_fade;
                if (cmd.div_start) state_next = CS_DIVIDE;
            end
            CS_DIVIDE: begin
                if (status.div_done) state_next = CS_IDLE;
            end
            default: begin
                state_next = CS_IDLE;
            end
        endcase
        m_valid_next = accept || (m_valid_reg && !m_ready);
    end

    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// File: hdl/led_level_fade_ramp_top.sv
// LED level fade ramp generator: drive level, on/off and fade control
//
// usage: one input word per action (tick, start fade, set level, set on/off,
// toggle) on the s_ channel; every accepted word yields exactly one result
// word on the m_ channel with the level, on flag and fade flag after the
// action. results leave in input order through a single output register.
// a result is valid the cycle after its word is accepted.
// throughput: tick, set level, set on/off and toggle words are taken one per
// cycle while m_ready stays high. after a start fade the step interval is
// computed by a bit-serial divider, one quotient bit per cycle, and no new
// word is taken until it finishes.
// stall: while the receiver holds m_ready low the result stays put and
// s_ready drops; the next word is taken in the cycle the result leaves.
// reset: aresetn is synchronous, active low; level, flags and fade state
// clear to zero and no result is pending.
`default_nettype none

module led_level_fade_ramp_top #(
    parameter int TIME_BITS = lfr_pkg::TIME_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire lfr_pkg::in_word_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output lfr_pkg::out_word_t     m_data
);
    import lfr_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    lfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lfr_datapath #(
        .TIME_BITS(TIME_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_data  (m_data)
    );

    // every accepted word produces a result next cycle
    a_accept_gives_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid
    ) else $error("accepted word did not produce a result");

    // a start fade blocks input at once, as the interval divide begins
    a_fade_blocks_input: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.action == ACT_FADE) |=> !s_ready
    ) else $error("input taken during interval divide");

    // on flag always tracks a nonzero level
    a_on_matches_level: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.is_on == (m_data.drive_level != 8'd0))
    ) else $error("on flag disagrees with level");

endmodule

`default_nettype wire

// File: tb/led_level_fade_ramp_top_tb.sv
// self-checking testbench for the led level fade ramp: directed and random words
`default_nettype none

module led_level_fade_ramp_top_tb;

    import lfr_pkg::*;

    // action codes the block ignores
    localparam logic [2:0] ACT_SPARE_A = 3'd5;
    localparam logic [2:0] ACT_SPARE_B = 3'd6;
    localparam logic [2:0] ACT_SPARE_C = 3'd7;

    localparam int RANDOM_WORDS = 1000;
    localparam int LIMIT_CYCLES = 500000;
    localparam int DRAIN_CYCLES = TIME_BITS_DEF + 12;
    localparam int HOLD_CYCLES  = 200;
    localparam int MAX_LINES    = 40;

    class fade_scoreboard;
        bit [7:0]   level;
        bit         on_now;
        bit         fading;
        bit         fade_run;
        bit [7:0]   lvl_from;
        bit [7:0]   lvl_to;
        bit [31:0]  fade_ms;
        bit [31:0]  begin_ms;
        bit [31:0]  step_ms;
        out_word_t  expected_q[$];
        int         errors;
        int         checked;

        function void note_word(in_word_t w);
            bit [63:0] diff;
            bit [63:0] quo;
            bit [63:0] rem;
            bit [63:0] interval;
            bit [31:0] elapsed;
            bit [31:0] since;
            out_word_t e;
            case (w.action)
                ACT_TICK: begin
                    if (fading) begin
                        if (!fade_run) begin
                            level    = lvl_from;
                            begin_ms = w.now_ms;
                            fade_run = 1'b1;
                        end
                        elapsed = w.now_ms - begin_ms;
                        since   = w.now_ms - step_ms;
                        if (elapsed < fade_ms) begin
                            if (lvl_to != lvl_from) begin
                                diff = (lvl_to > lvl_from) ? lvl_to - lvl_from
                                                           : lvl_from - lvl_to;
                                quo = fade_ms / diff;
                                rem = fade_ms % diff;
                                // nearest integer, halves round up
                                interval = quo + ((2 * rem >= diff) ? 1 : 0);
                                if ({32'd0, since} >= interval) begin
                                    if (lvl_to > lvl_from) begin
                                        if (level != LEVEL_MAX) level++;
                                    end else begin
                                        if (level != 8'd0) level--;
                                    end
                                    step_ms = w.now_ms;
                                end
                            end
                        end else begin
                            level    = lvl_to;
                            fade_run = 1'b0;
                            fading   = 1'b0;
                        end
                    end
                    on_now = (level != 8'd0);
                end
                ACT_FADE: begin
                    lvl_from = w.level_a;
                    lvl_to   = w.level_b;
                    fade_ms  = w.span_ms;
                    fade_run = 1'b0;
                    fading   = 1'b1;
                end
                ACT_LEVEL: begin
                    level  = w.level_a;
                    on_now = (level != 8'd0);
                end
                ACT_SWITCH: begin
                    on_now = w.switch_on;
                    level  = on_now ? LEVEL_MAX : 8'd0;
                end
                ACT_TOGGLE: begin
                    on_now = !on_now;
                    level  = on_now ? LEVEL_MAX : 8'd0;
                end
                default: ;
            endcase
            e.drive_level = level;
            e.is_on       = on_now;
            e.in_fade     = fading;
            expected_q.push_back(e);
        endfunction

        task report(string msg);
            if (errors < MAX_LINES) $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_result(out_word_t got);
            out_word_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", checked));
            end else begin
                e = expected_q.pop_front();
                if (got.drive_level !== e.drive_level)
                    report($sformatf("result %0d drive_level got %0d want %0d",
                                     checked, got.drive_level, e.drive_level));
                if (got.is_on !== e.is_on)
                    report($sformatf("result %0d is_on got %b want %b",
                                     checked, got.is_on, e.is_on));
                if (got.in_fade !== e.in_fade)
                    report($sformatf("result %0d in_fade got %b want %b",
                                     checked, got.in_fade, e.in_fade));
            end
            checked++;
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    fade_scoreboard sb = new;

    bit          idle_en = 1'b1;
    int          words_sent;
    int          cycles;
    logic [31:0] clock_ms;

    led_level_fade_ramp_top u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("** led_level_fade_ramp_top: FAILED **");
            $finish;
        end
    end

    // receiver: checks results, idles at random, holds off for long stretches twice
    int hold_left;
    int next_hold_at = 200;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (aresetn && next_hold_at > 0 && sb.checked >= next_hold_at) begin
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= (next_hold_at < 600) ? 650 : 0;
            m_ready      <= 1'b0;
        end else begin
            m_ready <= !(idle_en && $urandom_range(0, 99) < 27);
        end
    end

    function automatic in_word_t mk(logic [2:0] act, logic [31:0] now, logic [7:0] a,
                                    logic [7:0] b, logic [31:0] span, logic sw);
        in_word_t w;
        w.action    = act;
        w.now_ms    = now;
        w.level_a   = a;
        w.level_b   = b;
        w.span_ms   = span;
        w.switch_on = sw;
        return w;
    endfunction

    task automatic send_word(in_word_t w);
        while (idle_en && $urandom_range(0, 99) < 27) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        sb.note_word(w);
        if (w.action <= ACT_TOGGLE) words_sent++;
    endtask

    task automatic send_tick(logic [31:0] now);
        send_word(mk(ACT_TICK, now, 8'($urandom), 8'($urandom), $urandom, 1'($urandom)));
    endtask

    // a fade with random content, its ticks, and now and then a level change inside
    task automatic fade_sequence();
        logic [7:0]  a;
        logic [7:0]  b;
        logic [31:0] span;
        logic [31:0] step_max;
        int          n_ticks;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) clock_ms = $urandom;
        else if (pick < 8) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
        a = 8'($urandom);
        b = ($urandom_range(0, 99) < 15) ? a : 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 5) span = $urandom;
        else if (pick < 10) span = 32'd0;
        else span = $urandom_range(1, 700);
        send_word(mk(ACT_FADE, $urandom, a, b, span, 1'($urandom)));
        step_max = (span > 700) ? 32'd500 : span / 6 + 3;
        n_ticks  = $urandom_range(4, 30);
        for (int k = 0; k < n_ticks; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                send_word(mk(ACT_LEVEL, $urandom, 8'($urandom), 8'($urandom), $urandom,
                             1'($urandom)));
            end else if (pick < 6) begin
                send_word(mk(ACT_SWITCH, $urandom, 8'($urandom), 8'($urandom), $urandom,
                             1'($urandom)));
            end else if (pick < 8) begin
                send_word(mk(ACT_TOGGLE, $urandom, 8'($urandom), 8'($urandom), $urandom,
                             1'($urandom)));
            end else begin
                clock_ms += $urandom_range(0, step_max);
                send_tick(clock_ms);
            end
        end
        if (span <= 700 && $urandom_range(0, 99) < 60) begin
            clock_ms += span + $urandom_range(0, 5);
            send_tick(clock_ms);
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // state after reset, ignored codes, plain level and switch actions
        send_word(mk(ACT_TICK, 32'd0, 8'd0, 8'd0, 32'd0, 1'b0));
        send_word(mk(ACT_SPARE_A, '1, '1, '1, '1, 1'b1));
        send_word(mk(ACT_SPARE_B, '1, '1, '1, '1, 1'b1));
        send_word(mk(ACT_SPARE_C, '0, '0, '0, '0, 1'b0));
        send_word(mk(ACT_LEVEL, '0, 8'd255, 8'd0, '0, 1'b0));
        send_word(mk(ACT_LEVEL, '0, 8'd0, 8'd255, '0, 1'b1));
        send_word(mk(ACT_SWITCH, '0, '0, '0, '0, 1'b1));
        send_word(mk(ACT_TOGGLE, '0, '0, '0, '0, 1'b0));
        send_word(mk(ACT_TOGGLE, '0, '0, '0, '0, 1'b0));
        send_word(mk(ACT_SWITCH, '1, '1, '1, '1, 1'b0));
        // rising fade, one unit per 10 ms; level forced to full scale saturates
        send_word(mk(ACT_FADE, '0, 8'd0, 8'd255, 32'd2550, 1'b0));
        send_tick(32'd1000);
        send_tick(32'd1010);
        send_tick(32'd1015);
        send_word(mk(ACT_LEVEL, '0, 8'd255, 8'd0, '0, 1'b0));
        send_tick(32'd1020);
        send_tick(32'd3550);
        // equal start and end: no step, still ends after the duration
        send_word(mk(ACT_FADE, '0, 8'd10, 8'd10, 32'd50, 1'b0));
        send_tick(32'd4000);
        send_tick(32'd4049);
        send_tick(32'd4050);
        // zero duration snaps on the first tick
        send_word(mk(ACT_FADE, '0, 8'd200, 8'd0, 32'd0, 1'b0));
        send_tick(32'd4100);
        // falling fade that hits zero early, then a fade across the time wrap
        send_word(mk(ACT_FADE, '0, 8'd5, 8'd0, 32'd1000, 1'b0));
        send_tick(32'd5000);
        send_word(mk(ACT_LEVEL, '0, 8'd0, 8'd0, '0, 1'b0));
        send_tick(32'd5200);
        send_word(mk(ACT_FADE, '0, 8'd0, 8'd3, 32'd30, 1'b1));
        send_tick(32'hFFFF_FFF8);
        send_tick(32'h0000_0002);
        send_word(mk(ACT_FADE, '1, 8'd0, 8'd255, '1, 1'b1));
        send_tick('1);

        words_sent = 0;
        clock_ms   = 32'd10000;
        while (words_sent < RANDOM_WORDS) begin
            // a long quiet stretch with no idling on either side
            idle_en = !(words_sent >= 400 && words_sent < 600);
            if ($urandom_range(0, 99) < 85) begin
                fade_sequence();
            end else begin
                repeat ($urandom_range(1, 4))
                    send_word(mk(3'($urandom_range(0, 7)), $urandom, 8'($urandom),
                                 8'($urandom), $urandom, 1'($urandom)));
            end
        end
        idle_en = 1'b1;
        s_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("** led_level_fade_ramp_top: PASSED **");
        end else begin
            $display("** led_level_fade_ramp_top: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hdl/lfr_pkg.sv
hdl/lfr_divider.sv
hdl/lfr_datapath.sv
hdl/lfr_ctrl.sv
hdl/led_level_fade_ramp_top.sv
tb/led_level_fade_ramp_top_tb.sv
